### design/cmpre_pkg.sv
// ----------------------------------------------------------------------------
// cmpre_pkg
// Shared constants, types and arithmetic helpers for the column max scorer.
// ----------------------------------------------------------------------------
package cmpre_pkg;

  localparam int SCORE_W     = 32;
  localparam int ROW_COUNT_W = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [ROW_COUNT_W-1:0]    row_count_t;

  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

  // register indexes (paddr[2])
  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

  typedef struct packed {
    score_t hi;
    score_t sec;
  } tops_t;

  function automatic score_t sat_add(input score_t a, input score_t b);
    logic signed [SCORE_W:0] s;
    s = (SCORE_W+1)'(a) + (SCORE_W+1)'(b);
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

  function automatic tops_t track_top(input tops_t t, input score_t v);
    tops_t r;
    r = t;
    if (v > t.hi) begin
      r.sec = t.hi;
      r.hi  = v;
    end else if (v > t.sec) begin
      r.sec = v;
    end
    return r;
  endfunction

endpackage

### design/cmpre_in_if.sv
// ----------------------------------------------------------------------------
// cmpre_in_if
// Valid/ready channel carrying one grid cell item.
// ----------------------------------------------------------------------------
interface cmpre_in_if #(
  parameter int CELL_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [CELL_WIDTH-1:0] cell_value;
  logic                         final_column;

  modport source (output valid, cell_value, final_column, input ready);
  modport sink   (input valid, cell_value, final_column, output ready);
endinterface

### design/cmpre_out_if.sv
// ----------------------------------------------------------------------------
// cmpre_out_if
// Valid/ready channel carrying one best score item.
// ----------------------------------------------------------------------------
interface cmpre_out_if
  import cmpre_pkg::*;
();
  logic   valid;
  logic   ready;
  score_t best_score;

  modport source (output valid, best_score, input ready);
  modport sink   (input valid, best_score, output ready);
endinterface

### design/column_max_plus_row_exclusion_dp.sv
// ----------------------------------------------------------------------------
// column_max_plus_row_exclusion_dp
// Column-by-column max-plus scorer with row exclusion.
// ----------------------------------------------------------------------------
// Cells enter on in_ch (valid/ready) in column-major order, one item per
// cell, with final_column set on cells of the grid's last column. The per-row
// scores live in a MAX_ROWS x 32 RAM; each cell reads its row in stage 0 and
// writes the updated score back in stage 1, so one item is taken per cycle
// while stage 1 is not held. A same-row read right behind a write (single-row
// grids) uses a bypass. After the last row of a final column, out_ch.valid
// rises once that cell leaves stage 1 and loads the output register; while
// the result waits there, cells keep flowing: only a second final column
// reaching stage 1 holds in_ch.ready low until the first result is taken.
// The user writes row_count (APB-style port, address 0) only while idle; the
// block does not enforce it. 0 counts as 1, values above MAX_ROWS as MAX_ROWS.
// Synchronous active-low reset sets row_count to 1, empties the pipeline and
// starts a new grid; the score RAM is not cleared (the first column fills it).
// ----------------------------------------------------------------------------
module column_max_plus_row_exclusion_dp
  import cmpre_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int CELL_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cmpre_in_if.sink              in_ch,
  cmpre_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  row_count_t row_count;

  cmpre_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_count (row_count)
  );

  cmpre_core #(
    .MAX_ROWS   (MAX_ROWS),
    .CELL_WIDTH (CELL_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_count (row_count),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

### design/cmpre_ram.sv
// ----------------------------------------------------------------------------
// cmpre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmpre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/cmpre_cfg.sv
// ----------------------------------------------------------------------------
// cmpre_cfg
// APB-style register file holding the row count.
// ----------------------------------------------------------------------------
module cmpre_cfg
  import cmpre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output row_count_t            row_count
);

  row_count_t row_count_r;
  row_count_t row_count_nxt;
  reg_idx_t   reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    row_count_nxt = row_count_r;
    prdata        = '0;
    unique case (reg_idx)
      REG_ROW_COUNT: begin
        prdata = CFG_DATA_W'(row_count_r);
        if (wr_en) begin
          row_count_nxt = pwdata[ROW_COUNT_W-1:0];
        end
      end
      REG_NONE: begin
        prdata = '0;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_W'(1);
    end else begin
      row_count_r <= row_count_nxt;
    end
  end

  assign row_count = row_count_r;

endmodule

### design/cmpre_core.sv
// ----------------------------------------------------------------------------
// cmpre_core
// Two-stage score pipeline: stage 0 issues the score store read, stage 1
// updates the score, writes it back and tracks the column's top two.
// ----------------------------------------------------------------------------
module cmpre_core
  import cmpre_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int CELL_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  row_count_t row_count,
  cmpre_in_if.sink   in_ch,
  cmpre_out_if.source out_ch
);

  localparam int PW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_MX = $clog2(MAX_ROWS + 1);
  localparam int CNT_W  = (CNT_MX > ROW_COUNT_W) ? CNT_MX : ROW_COUNT_W;

  typedef struct packed {
    logic [PW-1:0]                addr;
    logic signed [CELL_WIDTH-1:0] cval;
    logic                         fin;
    logic                         last;
    logic                         one_row;
  } s1_t;

  // stage 0
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0] rows_eff;
  logic [CNT_W-1:0] rc_ext;
  logic             in_last;
  logic             accept;

  // stage 1
  logic   s1_vld_r, s1_vld_nxt;
  s1_t    s1_r;
  logic   s1_fire;
  logic   s1_emit;
  logic   fwd_vld_r, fwd_vld_nxt;
  score_t fwd_data_r;
  score_t rd_data;
  score_t old_score;
  score_t cell_ext;
  score_t other;
  score_t cand;
  score_t score;
  tops_t  upd;

  logic   first_r, first_nxt;
  tops_t  prev_r, prev_nxt;
  tops_t  cur_r, cur_nxt;

  logic   out_vld_r, out_vld_nxt;
  score_t out_data_r;

  localparam tops_t TOPS_CLR = '{hi: SCORE_MIN, sec: SCORE_MIN};

  // ---- stage 0: row sequencing and store read
  assign rc_ext = CNT_W'(row_count);

  always_comb begin
    if (rc_ext == '0) begin
      rows_eff = CNT_W'(1);
    end else if (rc_ext > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = rc_ext;
    end
  end

  assign in_last     = (CNT_W'(pos_r) + CNT_W'(1)) >= rows_eff;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_vld_r || s1_fire;
  assign pos_nxt     = !accept ? pos_r : (in_last ? '0 : PW'(CNT_W'(pos_r) + CNT_W'(1)));

  cmpre_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_ROWS),
    .AW    (PW)
  ) u_scores (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_r.addr),
    .wr_data (score),
    .rd_en   (accept),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  // ---- stage 1: score update
  assign s1_emit = s1_r.last && s1_r.fin;
  assign s1_fire = s1_vld_r && (!s1_emit || !out_vld_r || out_ch.ready);
  assign s1_vld_nxt = accept || (s1_vld_r && !s1_fire);

  // same-row write in the read cycle is bypassed
  assign fwd_vld_nxt = accept ? (s1_fire && (s1_r.addr == pos_r))
                              : (fwd_vld_r && !s1_fire);

  assign old_score = fwd_vld_r ? fwd_data_r : rd_data;
  assign cell_ext  = SCORE_W'(s1_r.cval);
  assign other     = (old_score == prev_r.hi) ? prev_r.sec : prev_r.hi;

  always_comb begin
    if (s1_r.one_row) begin
      cand = cell_ext;
    end else begin
      cand = sat_add(cell_ext, other);
    end
    if (first_r) begin
      score = cell_ext;
    end else begin
      score = (cand > old_score) ? cand : old_score;
    end
    upd = track_top(cur_r, score);
  end

  always_comb begin
    first_nxt   = first_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (s1_fire) begin
      if (!s1_r.last) begin
        cur_nxt = upd;
      end else if (s1_r.fin) begin
        prev_nxt    = TOPS_CLR;
        cur_nxt     = TOPS_CLR;
        first_nxt   = 1'b1;
        out_vld_nxt = 1'b1;
      end else begin
        prev_nxt  = upd;
        cur_nxt   = TOPS_CLR;
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      first_r   <= 1'b1;
      prev_r    <= TOPS_CLR;
      cur_r     <= TOPS_CLR;
      out_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      s1_vld_r  <= s1_vld_nxt;
      fwd_vld_r <= fwd_vld_nxt;
      first_r   <= first_nxt;
      prev_r    <= prev_nxt;
      cur_r     <= cur_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.addr    <= pos_r;
      s1_r.cval    <= in_ch.cell_value;
      s1_r.fin     <= in_ch.final_column;
      s1_r.last    <= in_last;
      s1_r.one_row <= (rows_eff == CNT_W'(1));
      fwd_data_r   <= score;
    end
    if (s1_fire && s1_emit) begin
      out_data_r <= upd.hi;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.best_score = out_data_r;

  // ---- checks
  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_emit |=> out_vld_r)
    else $error("final row did not load the result register");

  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_vld_r |-> s1_vld_r)
    else $error("bypass armed with empty stage 1");

  a_cur_order: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.sec <= cur_r.hi)
    else $error("running second exceeds running highest");

  a_prev_order: assert property (@(posedge clk) disable iff (!rst_n)
    prev_r.sec <= prev_r.hi)
    else $error("previous second exceeds previous highest");

endmodule

### bench/column_score_checker.sv
// ----------------------------------------------------------------------------
// column_score_checker
// Watches the cell, score and register ports of the column max scorer, keeps
// its own copy of the per-row scores and column tops, predicts best_score for
// each finished grid and compares it with what the block emits.
// ----------------------------------------------------------------------------
module column_score_checker
  import cmpre_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int CELL_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [CELL_WIDTH-1:0] in_cell,
  input  logic                         in_final,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  score_t                       out_best,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output int unsigned                  pending,
  output int unsigned                  fails
);

  row_count_t  rows_cfg;
  score_t      row_score [MAX_ROWS];
  score_t      prev_hi, prev_sec, cur_hi, cur_sec;
  int unsigned row_pos;
  bit          first_col;
  score_t      best_q [$];
  int unsigned fail_n = 0;
  int unsigned depth = 0;

  assign pending = depth;
  assign fails   = fail_n;

  function automatic score_t clamp_sum(input score_t a, input score_t b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SCORE_MAX)) return SCORE_MAX;
    if (s < longint'(SCORE_MIN)) return SCORE_MIN;
    return score_t'(s);
  endfunction

  function automatic void new_grid();
    prev_hi   = SCORE_MIN;
    prev_sec  = SCORE_MIN;
    cur_hi    = SCORE_MIN;
    cur_sec   = SCORE_MIN;
    row_pos   = 0;
    first_col = 1'b1;
  endfunction

  function automatic void score_cell(input logic signed [CELL_WIDTH-1:0] c, input logic fin);
    int unsigned n;
    int unsigned r;
    score_t      cell_sx;
    score_t      old;
    score_t      cand;
    score_t      other;
    score_t      sc;
    n = (rows_cfg == 0) ? 1 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    cell_sx = c;
    r = row_pos % MAX_ROWS;
    if (first_col) begin
      sc = cell_sx;
    end else begin
      old = row_score[r];
      if (n == 1) begin
        cand = cell_sx;
      end else begin
        other = (old == prev_hi) ? prev_sec : prev_hi;
        cand  = clamp_sum(cell_sx, other);
      end
      sc = (cand > old) ? cand : old;
    end
    row_score[r] = sc;
    if (sc > cur_hi) begin
      cur_sec = cur_hi;
      cur_hi  = sc;
    end else if (sc > cur_sec) begin
      cur_sec = sc;
    end
    if (row_pos + 1 < n) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    if (fin) begin
      best_q.push_back(cur_hi);
      new_grid();
    end else begin
      prev_hi   = cur_hi;
      prev_sec  = cur_sec;
      cur_hi    = SCORE_MIN;
      cur_sec   = SCORE_MIN;
      first_col = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    score_t want;
    if (!rst_n) begin
      rows_cfg = 1;
      foreach (row_score[i]) row_score[i] = '0;
      new_grid();
      best_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && reg_idx_t'(paddr[2]) == REG_ROW_COUNT) begin
        rows_cfg = pwdata[ROW_COUNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        score_cell(in_cell, in_final);
      end
      if (out_valid && out_ready) begin
        if (best_q.size() == 0) begin
          $error("best_score: no result expected, actual %0d", out_best);
          fail_n++;
        end else begin
          want = best_q.pop_front();
          if (out_best !== want) begin
            $error("best_score: expected %0d, actual %0d", want, out_best);
            fail_n++;
          end
        end
      end
    end
    depth = best_q.size();
  end

endmodule

### bench/column_max_plus_row_exclusion_dp_tb.sv
// ----------------------------------------------------------------------------
// column_max_plus_row_exclusion_dp_tb
// Drives grids of cells and row_count settings into the column max scorer,
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module column_max_plus_row_exclusion_dp_tb;
  import cmpre_pkg::*;

  localparam int ROWS_MAX  = 64;
  localparam int CELL_W    = 16;
  localparam int HOLD_OFF  = 4;
  localparam int MAX_CYCLE = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  rx_ready = 1'b0;
  logic                  calm = 1'b0;
  int unsigned           pending;
  int unsigned           fails;
  int unsigned           cycles = 0;
  int unsigned           sent = 0;
  int unsigned           grids = 0;
  int unsigned           rows_eff = 1;

  cmpre_in_if #(.CELL_WIDTH(CELL_W)) in_ch ();
  cmpre_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  column_max_plus_row_exclusion_dp #(
    .MAX_ROWS  (ROWS_MAX),
    .CELL_WIDTH(CELL_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  column_score_checker #(
    .MAX_ROWS  (ROWS_MAX),
    .CELL_WIDTH(CELL_W)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_cell  (in_ch.cell_value),
    .in_final (in_ch.final_column),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_best (out_ch.best_score),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pending  (pending),
    .fails    (fails)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    rx_ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cell(input logic signed [CELL_W-1:0] c, input logic fin);
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cell_value   <= c;
    in_ch.final_column <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rows(input int unsigned v);
    drain();
    write_reg(REG_ROW_COUNT, v);
    rows_eff = (v == 0) ? 1 : (v > ROWS_MAX) ? ROWS_MAX : v;
  endtask

  function automatic logic signed [CELL_W-1:0] pick_cell();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(CELL_W-1){1'b0}}};
      1:       return {1'b0, {(CELL_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      4:       return CELL_W'($urandom_range(0, 3));
      default: return CELL_W'($urandom);
    endcase
  endfunction

  // flags on all but the last row are noise
  task automatic run_grid(input int unsigned n_cols);
    logic fin;
    for (int col = 0; col < n_cols; col++) begin
      for (int row = 0; row < rows_eff; row++) begin
        if (row == rows_eff - 1) fin = (col == n_cols - 1);
        else fin = $urandom_range(0, 1);
        send_cell(pick_cell(), fin);
      end
    end
    grids++;
  endtask

  initial begin
    int unsigned phase;
    int unsigned v;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cell_value   <= '0;
    in_ch.final_column <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one row at its reset setting, cell extremes
    send_cell(16'sh7fff, 1'b0);
    send_cell(-16'sh8000, 1'b1);
    send_cell(-16'sh8000, 1'b1);

    // zero rows acts as one
    set_rows(0);
    send_cell(16'sd5, 1'b1);

    // tied highest in the first column
    set_rows(3);
    send_cell(16'sd7, 1'b0);
    send_cell(16'sd7, 1'b1);
    send_cell(16'sd2, 1'b0);
    send_cell(16'sd10, 1'b1);
    send_cell(-16'sh8000, 1'b0);
    send_cell(16'sh7fff, 1'b1);

    // row count lowered partway through a column
    set_rows(4);
    send_cell(16'sd4, 1'b0);
    send_cell(-16'sd3, 1'b1);
    send_cell(16'sd8, 1'b0);
    send_cell(16'sd1, 1'b0);
    send_cell(16'sd3, 1'b0);
    send_cell(-16'sd5, 1'b1);
    set_rows(2);
    send_cell(16'sd9, 1'b0);
    send_cell(16'sd1, 1'b0);
    send_cell(-16'sd2, 1'b1);
    grids += 5;

    phase = 0;
    while (sent < 750 || grids < 40) begin
      calm <= (sent >= 300 && sent < 450);
      if (phase == 0) v = 64;
      else if (phase == 1) v = 127;
      else begin
        case ($urandom_range(0, 9))
          0:       v = 0;
          1:       v = 1;
          2:       v = 64;
          3:       v = $urandom_range(65, 127);
          default: v = $urandom_range(2, 8);
        endcase
      end
      set_rows(v);
      if (rows_eff >= ROWS_MAX) run_grid($urandom_range(1, 2));
      else repeat ($urandom_range(3, 6)) run_grid($urandom_range(1, 5));
      phase++;
    end

    drain();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### column_max_plus_row_exclusion_dp.f
design/cmpre_pkg.sv
design/cmpre_in_if.sv
design/cmpre_out_if.sv
design/cmpre_ram.sv
design/cmpre_cfg.sv
design/cmpre_core.sv
design/column_max_plus_row_exclusion_dp.sv
bench/column_score_checker.sv
bench/column_max_plus_row_exclusion_dp_tb.sv
